// File: src/bmp24_pkg.sv
// bmp24_pkg: shared types, codes and header helpers for the bmp24 stream encoder
// no dependencies; used by every module of the block
package bmp24_pkg;

   // register indexes on the csr port
   localparam logic [1:0] CSR_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_CHANNELS = 2'd2;

   // channel count codes (zero and three both mean red-green-blue)
   localparam logic [1:0] CH_GREY = 2'd1;
   localparam logic [1:0] CH_RG   = 2'd2;
   localparam logic [1:0] CH_RGB  = 2'd3;

   // widths of the configuration registers and dimension arithmetic
   localparam int CFG_DIM_W = 13;
   localparam int DIM_W     = 16;
   localparam int ROW_W     = 18;

   // header layout
   localparam int          HDR_BYTES = 54;
   localparam logic [5:0]  HDR_LAST_IDX = 6'd53;
   localparam logic [5:0]  PIX_LAST_IDX = 6'd2;
   localparam logic [31:0] HDR_BYTES32  = 32'd54;
   localparam logic [5:0]  OFS_FILE   = 6'h02;
   localparam logic [5:0]  OFS_OFFSET = 6'h0A;
   localparam logic [5:0]  OFS_INFO   = 6'h0E;
   localparam logic [5:0]  OFS_WIDTH  = 6'h12;
   localparam logic [5:0]  OFS_HEIGHT = 6'h16;
   localparam logic [5:0]  OFS_PLANES = 6'h1A;
   localparam logic [5:0]  OFS_BPP    = 6'h1C;
   localparam logic [5:0]  OFS_DATA   = 6'h22;
   localparam logic [5:0]  OFS_XRES   = 6'h27;
   localparam logic [5:0]  OFS_YRES   = 6'h2B;

   // one classified pixel waiting for the back end
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic       hdr;
      logic [1:0] pad;
      logic       eof;
   } pix_entry_type;

   // header fields handed to the back end
   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [31:0]      data_size;
      logic [31:0]      total_len;
   } hdr_info_type;

   // back end phase within one queue entry
   typedef enum logic [1:0] {
      BK_START,
      BK_HDR,
      BK_PIX,
      BK_PAD
   } back_state_type;

   // clamp a dimension register to 1..maxv
   function automatic logic [DIM_W-1:0] clamp_dim(logic [CFG_DIM_W-1:0] v,
                                                   logic [DIM_W-1:0] maxv);
      logic [DIM_W-1:0] ext;
      ext = DIM_W'(v);
      if (ext == '0)
         return DIM_W'(1);
      else if (ext > maxv)
         return maxv;
      else
         return ext;
   endfunction

   // byte of a 32-bit little-endian field at offset base
   function automatic logic [7:0] le_byte(logic [31:0] v, logic [5:0] idx,
                                          logic [5:0] base);
      logic [5:0] rel;
      rel = idx - base;
      return v[8*rel[1:0] +: 8];
   endfunction

   // header byte at a given index
   function automatic logic [7:0] hdr_byte(logic [5:0] idx, hdr_info_type info);
      logic [7:0] b;
      b = 8'h00;
      if (idx == 6'd0)
         b = 8'h42;
      else if (idx == 6'd1)
         b = 8'h4D;
      else if (idx >= OFS_FILE && idx < OFS_FILE + 6'd4)
         b = le_byte(info.total_len, idx, OFS_FILE);
      else if (idx == OFS_OFFSET)
         b = 8'h36;
      else if (idx == OFS_INFO)
         b = 8'h28;
      else if (idx >= OFS_WIDTH && idx < OFS_WIDTH + 6'd4)
         b = le_byte(32'(info.width), idx, OFS_WIDTH);
      else if (idx >= OFS_HEIGHT && idx < OFS_HEIGHT + 6'd4)
         b = le_byte(32'(info.height), idx, OFS_HEIGHT);
      else if (idx == OFS_PLANES)
         b = 8'd1;
      else if (idx == OFS_BPP)
         b = 8'd24;
      else if (idx >= OFS_DATA && idx < OFS_DATA + 6'd4)
         b = le_byte(info.data_size, idx, OFS_DATA);
      else if (idx == OFS_XRES || idx == OFS_YRES)
         b = 8'd1;
      return b;
   endfunction

endpackage

// File: src/bmp24_front.sv
// bmp24_front: accepts pixels, orders their bytes and tracks column, row and header state
// depends on bmp24_pkg
module bmp24_front
   import bmp24_pkg::*;
#(
   parameter int CW = 13,
   parameter int RW = 13
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [23:0]         req_tdata,
   input  logic [DIM_W-1:0]    width,
   input  logic [DIM_W-1:0]    height,
   input  logic [1:0]          channel_count,
   input  logic                q_full,
   output logic                q_push,
   output pix_entry_type       q_entry
);

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          hdr_done_ff, hdr_done_in;
   logic [CW:0]   col_inc;
   logic [RW:0]   row_inc;
   logic          row_end, frame_end;
   logic [7:0]    red, green, blue;

   assign red   = req_tdata[7:0];
   assign green = req_tdata[15:8];
   assign blue  = req_tdata[23:16];

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && req_tready;

   // end of row and end of frame checks
   assign col_inc   = {1'b0, col_ff} + (CW+1)'(1);
   assign row_inc   = {1'b0, row_ff} + (RW+1)'(1);
   assign row_end   = 17'(col_inc) >= 17'(width);
   assign frame_end = row_end && (17'(row_inc) >= 17'(height));

   // byte order for the back end
   always_comb begin
      case (channel_count)
         CH_GREY: begin
            q_entry.byte0 = red;
            q_entry.byte1 = red;
            q_entry.byte2 = red;
         end
         CH_RG: begin
            q_entry.byte0 = 8'h00;
            q_entry.byte1 = green;
            q_entry.byte2 = red;
         end
         default: begin
            q_entry.byte0 = blue;
            q_entry.byte1 = green;
            q_entry.byte2 = red;
         end
      endcase
      q_entry.hdr = !hdr_done_ff;
      q_entry.pad = row_end ? width[1:0] : 2'd0;
      q_entry.eof = frame_end;
   end

   // next counter values
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      hdr_done_in = hdr_done_ff;
      if (q_push) begin
         hdr_done_in = !frame_end;
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_inc[RW-1:0];
         end else begin
            col_in = col_inc[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         hdr_done_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         hdr_done_ff <= hdr_done_in;
      end
   end

endmodule

// File: src/bmp24_queue.sv
// bmp24_queue: two-entry register queue between the front and back ends
// depends on bmp24_pkg
module bmp24_queue
   import bmp24_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  pix_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output pix_entry_type head
);

   localparam int DEPTH = 2;
   localparam int AW    = $clog2(DEPTH);

   pix_entry_type     slot_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [AW:0]       count_ff, count_in;

   assign full       = count_ff == (AW+1)'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ptr_ff] <= push_entry;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (AW+1)'(DEPTH))
      else $error("queue fill beyond depth");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue popped while empty");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + (AW+1)'(1))
      else $error("queue fill did not grow on push");

endmodule

// File: src/bmp24_back.sv
// bmp24_back: sends header, pixel and padding bytes one beat a cycle while the receiver is ready and an entry waits
// depends on bmp24_pkg
module bmp24_back
   import bmp24_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  pix_entry_type head,
   output logic          pop,
   input  hdr_info_type  info,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata,   // out_byte[7:0]
   output logic          rsp_tlast,   // run_last
   output logic          rsp_tuser    // frame_last
);

   back_state_type state_ff, state_in, phase;
   logic [5:0]     idx_ff, idx_in, cur_idx;
   logic           load;
   logic           done;
   logic [7:0]     byte_val;
   logic           valid_ff;
   logic [7:0]     data_ff;
   logic           last_ff, eof_ff;

   // output register loads if an entry waits and it is free or drained
   assign load = head_valid && (!valid_ff || rsp_tready);

   // phase of the byte at hand
   always_comb begin
      if (state_ff == BK_START) begin
         phase   = head.hdr ? BK_HDR : BK_PIX;
         cur_idx = '0;
      end else begin
         phase   = state_ff;
         cur_idx = idx_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      done     = 1'b0;
      case (phase)
         BK_HDR: begin
            if (cur_idx == HDR_LAST_IDX) begin
               state_in = BK_PIX;
               idx_in   = '0;
            end else begin
               state_in = BK_HDR;
               idx_in   = cur_idx + 6'd1;
            end
         end
         BK_PIX: begin
            if (cur_idx == PIX_LAST_IDX) begin
               if (head.pad != 2'd0) begin
                  state_in = BK_PAD;
                  idx_in   = '0;
               end else begin
                  state_in = BK_START;
                  done     = 1'b1;
               end
            end else begin
               state_in = BK_PIX;
               idx_in   = cur_idx + 6'd1;
            end
         end
         BK_PAD: begin
            if (cur_idx == 6'(head.pad) - 6'd1) begin
               state_in = BK_START;
               done     = 1'b1;
            end else begin
               state_in = BK_PAD;
               idx_in   = cur_idx + 6'd1;
            end
         end
         default: begin
            state_in = BK_START;
         end
      endcase
   end

   // byte value
   always_comb begin
      case (phase)
         BK_HDR:  byte_val = hdr_byte(cur_idx, info);
         BK_PIX: begin
            case (cur_idx[1:0])
               2'd0:    byte_val = head.byte0;
               2'd1:    byte_val = head.byte1;
               default: byte_val = head.byte2;
            endcase
         end
         default: byte_val = 8'h00;
      endcase
   end

   assign pop = load && done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_START;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            state_ff <= state_in;
            idx_ff   <= idx_in;
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= byte_val;
         last_ff <= done;
         eof_ff  <= done && head.eof;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = eof_ff;

   a_eof_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame end beat without run end");

   a_hdr_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_HDR |-> idx_ff <= HDR_LAST_IDX)
      else $error("header index out of range");

   a_pad_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_PAD |-> head_valid && idx_ff < 6'(head.pad))
      else $error("padding index beyond row padding");

endmodule

// File: src/bmp24_stream_encoder_unit.sv
// bmp24_stream_encoder_unit: pixel stream in, 24-bit BMP byte stream out
// path: an accepted pixel is registered in the queue, then its bytes in the output register,
// one byte per cycle while the receiver is ready and the queue holds an entry; 3 bytes per pixel,
// plus 54 for a header and 0 to 3 for row padding, through the single-byte port of the back end
// reset: synchronous, clears counters and queue, registers to width 1, height 1, three channels
// depends on bmp24_pkg, bmp24_front, bmp24_queue, bmp24_back
module bmp24_stream_encoder_unit
   import bmp24_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [23:0]          req_tdata,   // red_value[7:0], green_value[15:8], blue_value[23:16]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // out_byte[7:0]
   output logic                 rsp_tlast,   // run_last
   output logic                 rsp_tuser,   // frame_last
   input  logic                 csr_wen,
   input  logic [1:0]           csr_index,
   input  logic [CFG_DIM_W-1:0] csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1);
   localparam logic [DIM_W-1:0] MAX_W16 = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] MAX_H16 = DIM_W'(MAX_HEIGHT);

   logic [CFG_DIM_W-1:0] width_ff, height_ff;
   logic [1:0]           chan_ff;
   logic [DIM_W-1:0]     w_clamp, h_clamp;
   logic [DIM_W-1:0]     w_s1_ff, h_s1_ff;
   logic [ROW_W-1:0]     row_bytes_s1_ff;
   logic [DIM_W-1:0]     w_s2_ff, h_s2_ff;
   logic [31:0]          data_s2_ff;
   hdr_info_type         info_ff;
   logic                 q_full, q_push, q_pop, q_head_valid;
   pix_entry_type        q_entry, q_head;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_DIM_W'(1);
         height_ff <= CFG_DIM_W'(1);
         chan_ff   <= CH_RGB;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_WIDTH:    width_ff  <= csr_wdata;
            CSR_HEIGHT:   height_ff <= csr_wdata;
            CSR_CHANNELS: chan_ff   <= csr_wdata[1:0];
            default:      ;
         endcase
      end
   end

   assign w_clamp = clamp_dim(width_ff, MAX_W16);
   assign h_clamp = clamp_dim(height_ff, MAX_H16);

   // header size pipeline: row bytes, then data size, then file size
   always_ff @(posedge clock) begin
      w_s1_ff         <= w_clamp;
      h_s1_ff         <= h_clamp;
      row_bytes_s1_ff <= ROW_W'(w_clamp) * ROW_W'(3) + ROW_W'(w_clamp[1:0]);
      w_s2_ff         <= w_s1_ff;
      h_s2_ff         <= h_s1_ff;
      data_s2_ff      <= 32'(row_bytes_s1_ff * h_s1_ff);
      info_ff.width     <= w_s2_ff;
      info_ff.height    <= h_s2_ff;
      info_ff.data_size <= data_s2_ff;
      info_ff.total_len <= data_s2_ff + HDR_BYTES32;
   end

   bmp24_front #(
      .CW (CW),
      .RW (RW)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .width         (w_clamp),
      .height        (h_clamp),
      .channel_count (chan_ff),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (q_entry)
   );

   bmp24_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head       (q_head)
   );

   bmp24_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head       (q_head),
      .pop        (q_pop),
      .info       (info_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: test/bmp24_stream_checker.sv
// bmp24_stream_checker: watches the pixel, byte and csr ports of the bmp24 encoder,
// predicts every file byte from its own copy of the registers and counters, and compares
// depends on bmp24_pkg for register indexes, channel codes and header offsets
module bmp24_stream_checker
   import bmp24_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [23:0]          req_tdata,   // red_value[7:0], green_value[15:8], blue_value[23:16]
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [7:0]           rsp_tdata,   // out_byte[7:0]
   input  logic                 rsp_tlast,
   input  logic                 rsp_tuser,
   input  logic                 csr_wen,
   input  logic [1:0]           csr_index,
   input  logic [CFG_DIM_W-1:0] csr_wdata,
   output int                   error_count,
   output int                   bytes_pending
);

   typedef struct packed {
      logic [7:0] value;
      logic       pixel_end;
      logic       file_end;
   } file_beat_type;

   file_beat_type        file_bytes_due[$];
   file_beat_type        due_beat;
   logic [CFG_DIM_W-1:0] width_reg;
   logic [CFG_DIM_W-1:0] height_reg;
   logic [1:0]           channels_reg;
   logic [12:0]          column_idx;
   logic [12:0]          row_idx;
   logic                 header_sent;

   // dimension register clamped to 1..limit
   function automatic logic [12:0] bound_dim(logic [CFG_DIM_W-1:0] v, int limit);
      if (v == '0)
         return 13'd1;
      if (int'(v) > limit)
         return 13'(limit);
      return 13'(v);
   endfunction

   // all file bytes caused by one pixel, header first where a frame starts
   task automatic encode_pixel(input logic [7:0] red, input logic [7:0] green,
                               input logic [7:0] blue);
      logic [12:0] w;
      logic [12:0] h;
      logic [31:0] w32;
      logic [31:0] h32;
      int          pad;
      logic [63:0] data_len;
      logic [63:0] file_len;
      logic [7:0]  hdr[HDR_BYTES];
      logic [7:0]  out_bytes[$];
      logic        eof;
      w = bound_dim(width_reg, MAX_WIDTH);
      h = bound_dim(height_reg, MAX_HEIGHT);
      w32 = 32'(w);
      h32 = 32'(h);
      pad = (4 - (3 * int'(w)) % 4) % 4;
      eof = 1'b0;
      // header at the first pixel of a frame
      if (!header_sent) begin
         data_len = 64'(3 * int'(w) + pad) * 64'(h);
         file_len = data_len + 64'(HDR_BYTES);
         foreach (hdr[k]) hdr[k] = 8'h00;
         hdr[0] = "B";
         hdr[1] = "M";
         for (int k = 0; k < 4; k++) begin
            hdr[int'(OFS_FILE) + k]   = file_len[8*k +: 8];
            hdr[int'(OFS_WIDTH) + k]  = w32[8*k +: 8];
            hdr[int'(OFS_HEIGHT) + k] = h32[8*k +: 8];
            hdr[int'(OFS_DATA) + k]   = data_len[8*k +: 8];
         end
         hdr[int'(OFS_OFFSET)] = 8'h36;
         hdr[int'(OFS_INFO)]   = 8'h28;
         hdr[int'(OFS_PLANES)] = 8'd1;
         hdr[int'(OFS_BPP)]    = 8'd24;
         hdr[int'(OFS_XRES)]   = 8'd1;
         hdr[int'(OFS_YRES)]   = 8'd1;
         foreach (hdr[k]) out_bytes.push_back(hdr[k]);
         header_sent = 1'b1;
      end
      // three bytes of pixel data
      case (channels_reg)
         CH_GREY: begin
            out_bytes.push_back(red);
            out_bytes.push_back(red);
            out_bytes.push_back(red);
         end
         CH_RG: begin
            out_bytes.push_back(8'h00);
            out_bytes.push_back(green);
            out_bytes.push_back(red);
         end
         default: begin
            out_bytes.push_back(blue);
            out_bytes.push_back(green);
            out_bytes.push_back(red);
         end
      endcase
      // end of row padding and end of frame
      column_idx = column_idx + 13'd1;
      if (column_idx >= w) begin
         column_idx = '0;
         repeat (pad) out_bytes.push_back(8'h00);
         row_idx = row_idx + 13'd1;
         if (row_idx >= h) begin
            row_idx = '0;
            header_sent = 1'b0;
            eof = 1'b1;
         end
      end
      foreach (out_bytes[k])
         file_bytes_due.push_back('{out_bytes[k], k == out_bytes.size() - 1,
                                    eof && (k == out_bytes.size() - 1)});
   endtask

   // sample all three ports at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         width_reg = CFG_DIM_W'(1);
         height_reg = CFG_DIM_W'(1);
         channels_reg = CH_RGB;
         column_idx = '0;
         row_idx = '0;
         header_sent = 1'b0;
         file_bytes_due.delete();
      end else begin
         // byte beat against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (file_bytes_due.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected byte %h last %b eof %b with nothing pending",
                           rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               due_beat = file_bytes_due.pop_front();
               if (due_beat.value !== rsp_tdata || due_beat.pixel_end !== rsp_tlast ||
                   due_beat.file_end !== rsp_tuser) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("byte mismatch: expected %h last %b eof %b, got %h last %b eof %b",
                              due_beat.value, due_beat.pixel_end, due_beat.file_end,
                              rsp_tdata, rsp_tlast, rsp_tuser);
               end
            end
         end
         // pixel beat
         if (req_tvalid && req_tready)
            encode_pixel(req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]);
         // register write
         if (csr_wen) begin
            case (csr_index)
               CSR_WIDTH:    width_reg = csr_wdata;
               CSR_HEIGHT:   height_reg = csr_wdata;
               CSR_CHANNELS: channels_reg = csr_wdata[1:0];
               default: ;
            endcase
         end
      end
      bytes_pending = file_bytes_due.size();
   end

endmodule

// File: test/tb_bmp24_stream_encoder_unit.sv
// tb_bmp24_stream_encoder_unit: drives pixels and register settings into the bmp24 encoder
// with random idling on both sides; bmp24_stream_checker predicts and compares the bytes
// depends on bmp24_pkg, bmp24_stream_encoder_unit and bmp24_stream_checker
module tb_bmp24_stream_encoder_unit;
   import bmp24_pkg::*;

   localparam int RANDOM_PIXELS = 210;
   localparam int IDLE_PCT      = 24;
   localparam logic [1:0] CH_NONE = 2'd0;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic [23:0]          req_tdata  = '0;
   logic                 rsp_tready = 1'b0;
   logic                 csr_wen    = 1'b0;
   logic [1:0]           csr_index  = CSR_WIDTH;
   logic [CFG_DIM_W-1:0] csr_wdata  = '0;
   logic                 req_tready;
   logic                 rsp_tvalid;
   logic [7:0]           rsp_tdata;
   logic                 rsp_tlast;
   logic                 rsp_tuser;
   int                   error_count;
   int                   bytes_pending;
   int                   req_idle_pct = IDLE_PCT;
   int                   rsp_idle_pct = IDLE_PCT;

   bmp24_stream_encoder_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   bmp24_stream_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .bytes_pending (bytes_pending)
   );

   // clock, period 8
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver stalls
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // run limit
   initial begin
      #(8 * 600_000);
      $display("[FAIL] regression broken");
      $finish;
   end

   // drop valid and hold off until every predicted byte has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (bytes_pending != 0);
   endtask

   // write all three registers, one per cycle
   task automatic program_regs(input logic [CFG_DIM_W-1:0] w, input logic [CFG_DIM_W-1:0] h,
                               input logic [1:0] ch);
      csr_wen <= 1'b1;
      csr_index <= CSR_WIDTH;
      csr_wdata <= w;
      @(negedge clock);
      csr_index <= CSR_HEIGHT;
      csr_wdata <= h;
      @(negedge clock);
      csr_index <= CSR_CHANNELS;
      csr_wdata <= CFG_DIM_W'(ch);
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   // one pixel beat, with random gaps ahead of it
   task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {blue, green, red};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   initial begin
      int sent;
      int phase;
      int w_val;
      int h_val;
      int ch_val;
      int npix;
      sent = 0;
      phase = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: one-pixel frames, three channels
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'hAA, 8'h55, 8'hA5);

      // grey, red-green and channel count zero
      wait_drained();
      program_regs(CFG_DIM_W'(1), CFG_DIM_W'(1), CH_GREY);
      send_pixel(8'h5A, 8'hC3, 8'h3C);
      wait_drained();
      program_regs(CFG_DIM_W'(1), CFG_DIM_W'(1), CH_RG);
      send_pixel(8'h81, 8'h7E, 8'hFF);
      wait_drained();
      program_regs(CFG_DIM_W'(1), CFG_DIM_W'(1), CH_NONE);
      send_pixel(8'h12, 8'h34, 8'h56);

      // zero dimensions clamp to one
      wait_drained();
      program_regs(CFG_DIM_W'(0), CFG_DIM_W'(0), CH_RGB);
      send_pixel(8'hFE, 8'h01, 8'h80);

      // oversize dimensions clamp to the maximum, then shrink mid-frame
      wait_drained();
      program_regs(CFG_DIM_W'(8191), CFG_DIM_W'(8191), CH_RGB);
      send_pixel(8'h11, 8'h22, 8'h33);
      send_pixel(8'h44, 8'h55, 8'h66);
      wait_drained();
      program_regs(CFG_DIM_W'(2), CFG_DIM_W'(2), CH_RGB);
      send_pixel(8'h77, 8'h88, 8'h99);
      send_pixel(8'hAA, 8'hBB, 8'hCC);
      send_pixel(8'hDD, 8'hEE, 8'hFF);

      // exact maximum, then a bound the counts already reach
      wait_drained();
      program_regs(CFG_DIM_W'(4096), CFG_DIM_W'(4096), CH_RG);
      send_pixel(8'h0F, 8'hF0, 8'h00);
      wait_drained();
      program_regs(CFG_DIM_W'(1), CFG_DIM_W'(1), CH_GREY);
      send_pixel(8'hF0, 8'h0F, 8'hFF);

      // small full frame with row padding
      wait_drained();
      program_regs(CFG_DIM_W'(3), CFG_DIM_W'(2), CH_RGB);
      repeat (6) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));

      // random settings, mostly whole frames of small images
      while (sent < RANDOM_PIXELS) begin
         phase++;
         ch_val = $urandom_range(3);
         case ($urandom_range(11))
            0: begin
               case ($urandom_range(3))
                  0: w_val = 0;
                  1: w_val = 4095;
                  2: w_val = 4096;
                  default: w_val = 8191;
               endcase
               h_val = $urandom_range(1, 4);
               npix = $urandom_range(1, 4);
            end
            1: begin
               case ($urandom_range(2))
                  0: h_val = 0;
                  1: h_val = 4096;
                  default: h_val = 8191;
               endcase
               w_val = $urandom_range(1, 6);
               npix = $urandom_range(1, 2 * w_val);
            end
            default: begin
               w_val = $urandom_range(1, 9);
               h_val = $urandom_range(1, 4);
               if ($urandom_range(3) == 0)
                  npix = $urandom_range(1, w_val * h_val);
               else
                  npix = w_val * h_val * $urandom_range(1, 2);
            end
         endcase
         // keep the total close to the planned count
         if (npix > RANDOM_PIXELS - sent)
            npix = RANDOM_PIXELS - sent;
         wait_drained();
         program_regs(CFG_DIM_W'(w_val), CFG_DIM_W'(h_val), 2'(ch_val));
         // a long stretch with no idling on either side
         req_idle_pct = (phase >= 4 && phase <= 7) ? 0 : IDLE_PCT;
         rsp_idle_pct = req_idle_pct;
         repeat (npix) begin
            if ($urandom_range(29) == 0)
               wait_drained();
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
            sent++;
         end
      end

      wait_drained();
      repeat (16) @(negedge clock);
      if (error_count == 0 && bytes_pending == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: filelist.f
src/bmp24_pkg.sv
src/bmp24_front.sv
src/bmp24_queue.sv
src/bmp24_back.sv
src/bmp24_stream_encoder_unit.sv
test/bmp24_stream_checker.sv
test/tb_bmp24_stream_encoder_unit.sv
